// ===== design/positional_list_engine_unit_assert.svh =====
// assertion helpers shared by the checker
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== design/ple_pkg.sv =====
`timescale 1ns / 1ps
package ple_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int OP_W    = 2;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int ST_W    = 3;
  localparam int CMP_W   = POS_W + 1;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [ST_W-1:0] ST_BEYOND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic exec;   // accepted request, execute in this cycle
    logic step;   // emit one traverse beat and rotate
  } ple_cmd_t;

  typedef struct packed {
    logic empty;
    logic trav_last;
  } ple_sts_t;

endpackage

// ===== design/ple_ctrl.sv =====
`timescale 1ns / 1ps
module ple_ctrl
  import ple_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_op,
  output logic            out_valid,
  input  logic            out_stall,
  output ple_cmd_t        cmd,
  input  ple_sts_t        sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TRAV = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, accept, trav_start, load;

  // output register can take a new beat this cycle
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign trav_start = accept && (in_op == OP_TRAVERSE) && !sts.empty;

  assign cmd.exec = accept;
  assign cmd.step = (state_r == S_TRAV) && out_free;

  assign load = (accept && !trav_start) || cmd.step;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (trav_start) state_nxt = S_TRAV;
      end
      S_TRAV: begin
        if (cmd.step && sts.trav_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/ple_datapath.sv =====
`timescale 1ns / 1ps
module ple_datapath
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  input  ple_cmd_t                cmd,
  output ple_sts_t                sts,
  output logic signed [VAL_W-1:0] out_element,
  output logic [ST_W-1:0]         out_status,
  output logic                    out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [VAL_W-1:0] slots_r [CAPACITY];
  logic signed [VAL_W-1:0] slots_nxt [CAPACITY];
  logic signed [VAL_W-1:0] below_w [CAPACITY];
  logic signed [VAL_W-1:0] above_w [CAPACITY];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] trav_cnt_r, trav_cnt_nxt;

  logic signed [VAL_W-1:0] element_r;
  logic [ST_W-1:0]         status_r;
  logic                    last_r;

  logic [CMP_W-1:0] cnt_x, pos_x, ins_idx, del_idx;
  logic             full, empty;
  logic [ST_W-1:0]  req_status;
  logic             do_ins, do_del, emit_req;

  assign cnt_x   = CMP_W'(count_r);
  assign pos_x   = CMP_W'(in_position);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign del_idx = pos_x - 1'b1;
  assign ins_idx = (in_op == OP_APPEND) ? cnt_x : pos_x - 1'b1;

  assign sts.empty     = empty;
  assign sts.trav_last = (trav_cnt_r == CNT_W'(count_r - 1'b1));

  // precedence of the error checks follows the request kind
  always_comb begin
    req_status = ST_OK;
    case (in_op)
      OP_INSERT: begin
        if (in_position == '0)        req_status = ST_BADPOS;
        else if (full)                req_status = ST_FULL;
        else if (pos_x > cnt_x + 1'b1) req_status = ST_BADPOS;
      end
      OP_APPEND: begin
        if (full) req_status = ST_FULL;
      end
      OP_DELETE: begin
        if (in_position == '0) req_status = ST_BADPOS;
        else if (empty)        req_status = ST_EMPTY;
        else if (pos_x > cnt_x) req_status = ST_BEYOND;
      end
      OP_TRAVERSE: begin
        if (empty) req_status = ST_EMPTY;
      end
      default: req_status = ST_OK;
    endcase
  end

  assign do_ins   = cmd.exec && (req_status == ST_OK) &&
                    ((in_op == OP_INSERT) || (in_op == OP_APPEND));
  assign do_del   = cmd.exec && (req_status == ST_OK) && (in_op == OP_DELETE);
  assign emit_req = cmd.exec && !((in_op == OP_TRAVERSE) && !empty);

  // neighbor taps for the shift network
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_lo
      assign below_w[g] = slots_r[g];
    end else begin : g_mid_lo
      assign below_w[g] = slots_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign above_w[g] = slots_r[g];
    end else begin : g_mid_hi
      assign above_w[g] = slots_r[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slots_nxt[i] = slots_r[i];
      if (do_ins) begin
        if (CMP_W'(i) == ins_idx)     slots_nxt[i] = in_value;
        else if (CMP_W'(i) > ins_idx) slots_nxt[i] = below_w[i];
      end else if (do_del) begin
        if (CMP_W'(i) >= del_idx) slots_nxt[i] = above_w[i];
      end else if (cmd.step) begin
        // rotate the occupied part so the head walks through the list
        if (CMP_W'(i) == cnt_x - 1'b1)    slots_nxt[i] = slots_r[0];
        else if (CMP_W'(i) < cnt_x - 1'b1) slots_nxt[i] = above_w[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins)      count_nxt = count_r + 1'b1;
    else if (do_del) count_nxt = count_r - 1'b1;
  end

  always_comb begin
    trav_cnt_nxt = trav_cnt_r;
    if (cmd.exec)      trav_cnt_nxt = '0;
    else if (cmd.step) trav_cnt_nxt = trav_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      trav_cnt_r <= '0;
    end else begin
      count_r    <= count_nxt;
      trav_cnt_r <= trav_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
    if (emit_req) begin
      element_r <= '0;
      status_r  <= req_status;
      last_r    <= 1'b1;
    end else if (cmd.step) begin
      element_r <= slots_r[0];
      status_r  <= ST_OK;
      last_r    <= sts.trav_last;
    end
  end

  assign out_element = element_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

endmodule

// ===== design/positional_list_engine_unit.sv =====
// insert, append and delete: a registered result beat, one request per cycle unless
//   out_stall holds a beat; traverse: one beat per cycle while not stalled, set by the
//   slot rotation that walks the head through the list (empty list: one status beat)
// a new request is taken once the last beat of a traverse has been loaded
// reset (rst_n low, synchronous) empties the list and drops any pending beat;
//   slot contents stay undefined until written
`timescale 1ns / 1ps
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_element,
  output logic [ST_W-1:0]         out_status,
  output logic                    out_last
);

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_op),
    .in_value    (in_value),
    .in_position (in_position),
    .cmd         (cmd),
    .sts         (sts),
    .out_element (out_element),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule

// ===== design/ple_checker.sv =====
`timescale 1ns / 1ps
`include "positional_list_engine_unit_assert.svh"
module ple_checker
  import ple_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [OP_W-1:0]         in_op,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_element,
  input logic [ST_W-1:0]         out_status,
  input logic                    out_last
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a held beat blocks new requests
  `PLE_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall)
  // error and status beats carry no element and close the request
  `PLE_ASSERT_NOW(a_status_only, out_valid && (out_status != ST_OK), (out_element == '0) && out_last)
  // single-beat requests answer in the next cycle
  `PLE_ASSERT_NEXT(a_one_cycle, in_acc && (in_op != OP_TRAVERSE), out_valid && out_last)
  `PLE_ASSERT_NEXT(a_hold_beat, out_valid && out_stall, out_valid && $stable(out_element) && $stable(out_status) && $stable(out_last))

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_op       (in_op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_element (out_element),
  .out_status  (out_status),
  .out_last    (out_last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import ple_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int TAIL_CYCLES = CAP + 8;

  typedef struct {
    logic signed [VAL_W-1:0] element;
    logic [ST_W-1:0]         status;
    logic                    last;
  } beat_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op;
  logic signed [VAL_W-1:0] in_value;
  logic [POS_W-1:0]        in_position;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_element;
  logic [ST_W-1:0]         out_status;
  logic                    out_last;

  // shadow of the list contents, head at index 0
  logic signed [VAL_W-1:0] list_shadow[$];
  beat_t                   expected_beats[$];

  bit idle_enable;
  int error_count;
  int requests_sent;
  int beats_checked;
  int traverse_count;
  int error_status_count;
  int peak_fill;

  positional_list_engine_unit #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_element(out_element),
    .out_status (out_status),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d beats outstanding", expected_beats.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void expect_status(input logic [ST_W-1:0] st);
    beat_t b;
    b.element = '0;
    b.status  = st;
    b.last    = 1'b1;
    expected_beats.push_back(b);
    if (st != ST_OK) error_status_count++;
  endfunction

  // update the shadow list and queue the beats one request should produce
  function automatic void apply_list_request(input logic [OP_W-1:0] op,
                                             input logic signed [VAL_W-1:0] value,
                                             input logic [POS_W-1:0] position);
    int    fill;
    beat_t b;
    fill = list_shadow.size();
    case (op)
      OP_INSERT: begin
        if (position == 0) expect_status(ST_BADPOS);
        else if (fill >= CAP) expect_status(ST_FULL);
        else if (int'(position) > fill + 1) expect_status(ST_BADPOS);
        else begin
          list_shadow.insert(int'(position) - 1, value);
          expect_status(ST_OK);
        end
      end
      OP_APPEND: begin
        if (fill >= CAP) expect_status(ST_FULL);
        else begin
          list_shadow.push_back(value);
          expect_status(ST_OK);
        end
      end
      OP_DELETE: begin
        if (position == 0) expect_status(ST_BADPOS);
        else if (fill == 0) expect_status(ST_EMPTY);
        else if (int'(position) > fill) expect_status(ST_BEYOND);
        else begin
          list_shadow.delete(int'(position) - 1);
          expect_status(ST_OK);
        end
      end
      default: begin
        traverse_count++;
        if (fill == 0) expect_status(ST_EMPTY);
        else begin
          for (int i = 0; i < fill; i++) begin
            b.element = list_shadow[i];
            b.status  = ST_OK;
            b.last    = (i == fill - 1);
            expected_beats.push_back(b);
          end
        end
      end
    endcase
    if (list_shadow.size() > peak_fill) peak_fill = list_shadow.size();
  endfunction

  // entered and left at a falling edge; prediction happens at the falling
  // edge after the accepting rising edge
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [VAL_W-1:0] value,
                              input logic [POS_W-1:0] position);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_value    = value;
    in_position = position;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    apply_list_request(op, value, position);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input bit for_insert);
    int limit;
    int r;
    limit = for_insert ? list_shadow.size() + 1 : list_shadow.size();
    r = $urandom_range(0, 9);
    if (r < 7 && limit > 0) return POS_W'($urandom_range(1, limit));
    if (r == 7) return '0;
    if (r == 8) return POS_W'(limit + 1);
    return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic random_request(input int grow_pct);
    logic [OP_W-1:0] op;
    if ($urandom_range(0, 99) < 10) op = OP_TRAVERSE;
    else if ($urandom_range(0, 99) < grow_pct) op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
    else op = OP_DELETE;
    send_request(op, pick_value(), pick_position(op != OP_DELETE));
  endtask

  task automatic test_empty_list();
    send_request(OP_TRAVERSE, $urandom, POS_W'($urandom));
    send_request(OP_DELETE, $urandom, 8'd0);
    send_request(OP_DELETE, $urandom, 8'd1);
    send_request(OP_DELETE, $urandom, 8'd255);
    send_request(OP_INSERT, 32'sd5, 8'd0);
    send_request(OP_INSERT, 32'sd6, 8'd2);
    drain_results();
  endtask

  task automatic test_insert_edges();
    send_request(OP_INSERT, 32'h7fff_ffff, 8'd1);
    send_request(OP_APPEND, 32'h8000_0000, 8'd0);
    send_request(OP_INSERT, -32'sd1, 8'd2);
    send_request(OP_INSERT, 32'sd0, 8'd4);
    send_request(OP_INSERT, 32'sd9, 8'd6);
    send_request(OP_INSERT, 32'sd9, 8'd255);
    send_request(OP_TRAVERSE, '0, '0);
    drain_results();
  endtask

  task automatic test_delete_edges();
    send_request(OP_DELETE, '1, 8'd0);
    send_request(OP_DELETE, '1, 8'd5);
    send_request(OP_DELETE, '1, 8'd255);
    send_request(OP_DELETE, '1, 8'd4);
    send_request(OP_DELETE, '1, 8'd1);
    send_request(OP_TRAVERSE, '1, '1);
    send_request(OP_DELETE, '0, 8'd2);
    send_request(OP_DELETE, '0, 8'd1);
    send_request(OP_TRAVERSE, '0, '0);
    drain_results();
  endtask

  // grow to capacity with random content, hit every full-list case, then empty it
  task automatic test_fill_and_empty();
    while (list_shadow.size() < CAP) begin
      if ($urandom_range(0, 1))
        send_request(OP_INSERT, pick_value(),
                     POS_W'($urandom_range(1, list_shadow.size() + 1)));
      else
        send_request(OP_APPEND, pick_value(), POS_W'($urandom));
    end
    send_request(OP_APPEND, pick_value(), POS_W'($urandom));
    send_request(OP_INSERT, pick_value(), 8'd0);
    send_request(OP_INSERT, pick_value(), 8'd1);
    send_request(OP_INSERT, pick_value(), 8'd255);
    send_request(OP_TRAVERSE, pick_value(), POS_W'($urandom));
    send_request(OP_DELETE, pick_value(), POS_W'(CAP + 1));
    send_request(OP_DELETE, pick_value(), POS_W'(CAP));
    send_request(OP_INSERT, pick_value(), POS_W'(CAP));
    while (list_shadow.size() > 0) begin
      send_request(OP_DELETE, pick_value(), POS_W'($urandom_range(1, list_shadow.size())));
      if ($urandom_range(0, 7) == 0) send_request(OP_TRAVERSE, pick_value(), POS_W'($urandom));
    end
    send_request(OP_TRAVERSE, pick_value(), POS_W'($urandom));
    drain_results();
  endtask

  task automatic test_random_mix(input int n_items, input int grow_pct);
    repeat (n_items) random_request(grow_pct);
    drain_results();
  endtask

  // receiver backpressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat element=%0d status=%0d last=%0b",
                                  out_element, out_status, out_last));
      end else begin
        want = expected_beats.pop_front();
        if (out_element !== want.element)
          report_mismatch($sformatf("element got %0d want %0d", out_element, want.element));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
        beats_checked++;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_INSERT;
    in_value    = '0;
    in_position = '0;
    idle_enable = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_insert_edges();
    test_delete_edges();
    test_fill_and_empty();
    test_random_mix(60, 75);
    test_random_mix(45, 25);
    idle_enable = 1'b0;
    test_random_mix(45, 50);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

    $display("ran %0d requests (%0d traverses), checked %0d beats, peak fill %0d of %0d",
             requests_sent, traverse_count, beats_checked, peak_fill, CAP);
    $display("error statuses seen: %0d, mismatches: %0d", error_status_count, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
